FILE: hw/rtl/gnc_pkg.sv
package gnc_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_IN_USE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_IN_USE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 9'd256;

    // operation codes
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_SET   = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] x_coord;
        logic [7:0] y_coord;
        logic       write_value;
    } item_t;

    typedef struct packed {
        logic       cell_alive;
        logic [3:0] neighbour_count;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // latch item, read row above
        logic rd_dn;    // read row below
        logic rd_mid;   // read addressed row
        logic add;      // add window of the row just read
        logic finish;   // final count, write-back, result
        logic clr;      // write one zero row of the clearing pass
    } gnc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
    } gnc_sts_t;

endpackage

FILE: hw/rtl/gnc_ctrl.sv
module gnc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gnc_pkg::gnc_sts_t sts,
    output gnc_pkg::gnc_cmd_t cmd,
    output logic              busy
);
    import gnc_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DN    = 3'd2;
    localparam logic [2:0] ST_MID   = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DN;
                end
            end
            ST_DN:
            begin
                cmd.rd_dn  = 1'b1;
                cmd.add    = 1'b1;
                state_next = ST_MID;
            end
            ST_MID:
            begin
                cmd.rd_mid = 1'b1;
                cmd.add    = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: hw/rtl/gnc_datapath.sv
module gnc_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gnc_pkg::item_t                     item,
    input  logic                               cfg_we,
    input  logic [gnc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gnc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  gnc_pkg::gnc_cmd_t                  cmd,
    output gnc_pkg::gnc_sts_t                  sts,
    output logic                               done,
    output gnc_pkg::result_t                   result
);
    import gnc_pkg::*;

    localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // one row of the grid per word
    logic [MAX_WIDTH-1:0] row_mem [MAX_HEIGHT];

    item_t                 item_reg;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [AW-1:0]         clr_cnt_reg;
    logic [MAX_WIDTH-1:0]  q_reg;
    logic                  q_ok_reg;
    logic [3:0]            acc_reg;
    logic                  done_reg;
    result_t               result_reg;

    logic [9:0]           row_sel;
    logic                 row_ok;
    logic                 mem_re;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [MAX_WIDTH-1:0] mem_wdata;
    logic [9:0]           col   [3];
    logic [CW-1:0]        cidx  [3];
    logic [2:0]           col_ok;
    logic [2:0]           win;
    logic [3:0]           win_sum;
    logic                 on_grid;
    logic                 new_cell;
    logic                 do_write;
    logic [MAX_WIDTH-1:0] row_wr;

    // row to read this cycle: above comes from the live input
    always_comb
    begin
        if (cmd.accept)
        begin
            row_sel = {2'b0, item.y_coord} - 10'd1;
        end
        else if (cmd.rd_dn)
        begin
            row_sel = {2'b0, item_reg.y_coord} + 10'd1;
        end
        else
        begin
            row_sel = {2'b0, item_reg.y_coord};
        end
        // a wrapped negative row is far above any height in use
        row_ok = (row_sel < {1'b0, height_reg}) && (int'(row_sel) < MAX_HEIGHT);
        mem_re = (cmd.accept || cmd.rd_dn || cmd.rd_mid) && row_ok;
    end

    // column window x-1, x, x+1 of the row held in q_reg
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            col[k]    = {2'b0, item_reg.x_coord} + 10'(k) - 10'd1;
            cidx[k]   = CW'(col[k]);
            col_ok[k] = (col[k] < {1'b0, width_reg}) && (int'(col[k]) < MAX_WIDTH);
            win[k]    = q_ok_reg && col_ok[k] && q_reg[cidx[k]];
        end
        win_sum = {3'b0, win[0]} + {3'b0, win[1]} + {3'b0, win[2]};
    end

    always_comb
    begin
        on_grid  = q_ok_reg && col_ok[1];
        new_cell = (item_reg.operation == OP_SET) ? item_reg.write_value : q_reg[cidx[1]];
        do_write = cmd.finish && on_grid && (item_reg.operation == OP_SET);
        row_wr   = q_reg;
        if (on_grid)
        begin
            row_wr[cidx[1]] = item_reg.write_value;
        end
        mem_we    = do_write || cmd.clr;
        mem_waddr = cmd.clr ? clr_cnt_reg : AW'(item_reg.y_coord);
        mem_wdata = cmd.clr ? '0 : row_wr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            q_reg <= row_mem[AW'(row_sel)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
        end
        if (cmd.finish)
        begin
            result_reg.cell_alive      <= on_grid && new_cell;
            result_reg.neighbour_count <= acc_reg + {3'b0, win[0]} + {3'b0, win[2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= SIZE_RESET;
            height_reg  <= SIZE_RESET;
            clr_cnt_reg <= '0;
            q_ok_reg    <= 1'b0;
            acc_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WIDTH_IN_USE:  width_reg  <= cfg_data;
                    REG_HEIGHT_IN_USE: height_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.accept || cmd.rd_dn || cmd.rd_mid)
            begin
                q_ok_reg <= row_ok;
            end
            if (cmd.accept)
            begin
                acc_reg <= '0;
            end
            else if (cmd.add)
            begin
                acc_reg <= acc_reg + win_sum;
            end
            done_reg <= cmd.finish;
        end
    end

    assign sts.clr_last = (clr_cnt_reg == AW'(MAX_HEIGHT - 1));
    assign done         = done_reg;
    assign result       = result_reg;

endmodule

FILE: hw/rtl/grid_cell_store_neighbour_count.sv
// Result: strobed on done after the start transfer is taken and the item's
// steps are through: rows above, below and at the cell are read in turn,
// then the write-back. busy stays high, so no new item is taken before it.
// Reset: sizes return to 256, then a clearing pass zeroes the grid, one row
// per cycle, with busy high. The receiver cannot stall.
module grid_cell_store_neighbour_count #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command side: item taken when start is high and busy is low
    input  logic                               start,
    output logic                               busy,
    input  gnc_pkg::item_t                     item,
    // result side: one-cycle strobe, no back-pressure
    output logic                               done,
    output gnc_pkg::result_t                   result,
    // register writes, accepted whenever cfg_we is high
    input  logic                               cfg_we,
    input  logic [gnc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gnc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gnc_pkg::*;

    gnc_cmd_t cmd;
    gnc_sts_t sts;

    // Controller: clear sweep after reset, then per item
    // accept (read row above) -> read row below -> read own row -> finish.
    gnc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath: row memory, size registers, 3-bit column windows and the
    // running neighbour count. Rows and columns outside the size in use
    // are masked, so edges read as dead and never wrap.
    gnc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .done      (done),
        .result    (result)
    );

endmodule
